// File: design/line_editor_erase_kill_unit_defines.svh
// Assertion macros for the line editor unit.
// Used by the datapath module; needs clk_i and rst_ni in scope.
`ifndef LINE_EDITOR_ERASE_KILL_UNIT_DEFINES_SVH
`define LINE_EDITOR_ERASE_KILL_UNIT_DEFINES_SVH

// prop must hold at every rising clock edge outside reset
`define LEEK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// cond must never be true outside reset
`define LEEK_ASSERT_NEVER(lbl, cond, msg) \
  `LEEK_ASSERT(lbl, !(cond), msg)

`endif

// File: design/leek_pkg.sv
// Shared types and constants for the line editor unit.
// No dependencies; imported by the controller, datapath and top level.
package leek_pkg;

  localparam int unsigned LineDepthDef = 64;
  localparam int unsigned CharW        = 8;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [CfgIdxW-1:0] REG_ERASE    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KILL     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LINE_END = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TEXT_END = 2'd3;

  localparam logic [CharW-1:0] ERASE_RST    = 8'd35;  // '#'
  localparam logic [CharW-1:0] KILL_RST     = 8'd64;  // '@'
  localparam logic [CharW-1:0] LINE_END_RST = 8'd10;  // newline
  localparam logic [CharW-1:0] TEXT_END_RST = 8'd36;  // '$'

  // controller -> datapath
  typedef struct packed {
    logic edit;   // apply erase / kill / append for the accepted beat
    logic flush;  // snapshot the line and clear the buffer
    logic rd;     // read store at the drain pointer
    logic load;   // load the output register and advance the pointer
  } leek_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_flush;   // incoming char is a line or text end code
    logic fill_zero;  // buffer currently empty
    logic last;       // next loaded beat ends the line
    logic out_free;   // output register can take a beat this cycle
  } leek_sts_t;

endpackage

// File: design/line_editor_erase_kill_unit.sv
// Line editor with erase and kill: one character per input beat, buffered
// lines drained on line end or text end. Top level; uses leek_pkg, leek_ctrl, leek_dp.
//
// Editing characters (erase, kill, ordinary text) are taken back to back, even
// while an earlier result still waits on the output. A line end or text end
// character starts a drain: after that beat input is held off while the line
// leaves, each result beat taking a store read and then an output load (the
// empty line marker only the load), and longer while the output stalls. The
// line store holds LineDepth characters; later ones are dropped and flagged
// on every beat of that line.
module line_editor_erase_kill_unit import leek_pkg::*; #(
  parameter int unsigned LineDepth = LineDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CharW-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // [7:0] char_in
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [7:0] char_out
  output logic               m_axis_tlast,  // last_of_line
  output logic [2:0]         m_axis_tuser   // [0] has_char, [1] chars_dropped, [2] end_of_text
);

  leek_cmd_t cmd;
  leek_sts_t sts;

  leek_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  leek_dp #(
    .LineDepth (LineDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_char_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_has_o   (m_axis_tuser[0]),
    .out_last_o  (m_axis_tlast),
    .out_drop_o  (m_axis_tuser[1]),
    .out_eot_o   (m_axis_tuser[2])
  );

endmodule

// File: design/leek_ctrl.sv
// Controller for the line editor: sequences input beats and line drains.
// Depends on leek_pkg for the command and status structs.
module leek_ctrl import leek_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  leek_sts_t sts_i,
  output leek_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.is_flush) begin
            cmd_o.flush = 1'b1;
            // empty line goes straight to the marker beat
            state_d = sts_i.fill_zero ? ST_WR : ST_RD;
          end else begin
            cmd_o.edit = 1'b1;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_WR;
      end
      ST_WR: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.last ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/leek_dp.sv
// Datapath for the line editor: config registers, line store, fill count,
// drain pointer and output register. Depends on leek_pkg and the defines header.
`include "line_editor_erase_kill_unit_defines.svh"
module leek_dp import leek_pkg::*; #(
  parameter int unsigned LineDepth = LineDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CharW-1:0]   cfg_data_i,
  input  logic [CharW-1:0]   in_char_i,
  input  leek_cmd_t          cmd_i,
  output leek_sts_t          sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [CharW-1:0]   out_char_o,
  output logic               out_has_o,
  output logic               out_last_o,
  output logic               out_drop_o,
  output logic               out_eot_o
);

  localparam int unsigned AW = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int unsigned CW = $clog2(LineDepth + 1);

  logic [CharW-1:0] erase_q, kill_q, line_end_q, text_end_q;
  logic [CharW-1:0] mem [LineDepth];
  logic [CharW-1:0] rd_data_q;
  logic [CW-1:0]    fill_q, len_q, ptr_q;
  logic             ovf_q, drop_q, eot_q;
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic             out_has_q, out_last_q, out_drop_q, out_eot_q;

  logic is_eot, is_flush, is_erase, is_kill, do_write, last;

  assign is_eot   = (in_char_i == text_end_q);
  assign is_flush = is_eot || (in_char_i == line_end_q);
  assign is_erase = (in_char_i == erase_q);
  assign is_kill  = (in_char_i == kill_q);
  assign do_write = cmd_i.edit && !is_erase && !is_kill && (fill_q < CW'(LineDepth));
  assign last     = (len_q == '0) || (ptr_q + CW'(1) == len_q);

  assign sts_o.is_flush  = is_flush;
  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.last      = last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q    <= ERASE_RST;
      kill_q     <= KILL_RST;
      line_end_q <= LINE_END_RST;
      text_end_q <= TEXT_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ERASE:    erase_q    <= cfg_data_i;
        REG_KILL:     kill_q     <= cfg_data_i;
        REG_LINE_END: line_end_q <= cfg_data_i;
        REG_TEXT_END: text_end_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      len_q  <= '0;
      ptr_q  <= '0;
      drop_q <= 1'b0;
      eot_q  <= 1'b0;
    end else begin
      if (cmd_i.flush) begin
        len_q  <= fill_q;
        drop_q <= ovf_q;
        eot_q  <= is_eot;
        ptr_q  <= '0;
        fill_q <= '0;
        ovf_q  <= 1'b0;
      end else if (cmd_i.edit) begin
        if (is_erase) begin
          if (fill_q != '0) fill_q <= fill_q - CW'(1);
        end else if (is_kill) begin
          fill_q <= '0;  // overflow flag stays until the flush
        end else if (do_write) begin
          fill_q <= fill_q + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.load) ptr_q <= ptr_q + CW'(1);
    end
  end

  // line store, no reset: only entries below the fill count are read
  always_ff @(posedge clk_i) begin
    if (do_write) mem[fill_q[AW-1:0]] <= in_char_i;
    if (cmd_i.rd) rd_data_q <= mem[ptr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_char_q <= (len_q == '0) ? '0 : rd_data_q;
      out_has_q  <= (len_q != '0);
      out_last_q <= last;
      out_drop_q <= drop_q;
      out_eot_q  <= eot_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_has_o   = out_has_q;
  assign out_last_o  = out_last_q;
  assign out_drop_o  = out_drop_q;
  assign out_eot_o   = out_eot_q;

  `LEEK_ASSERT_NEVER(a_fill_range, fill_q > CW'(LineDepth), "fill count above line depth")
  `LEEK_ASSERT(a_load_free, cmd_i.load |-> (!out_valid_q || out_ready_i), "load over held beat")
  `LEEK_ASSERT(a_flush_clears, cmd_i.flush |=> (fill_q == '0 && !ovf_q), "flush left line state")
  `LEEK_ASSERT(a_ptr_bound, (cmd_i.rd || cmd_i.load) |-> (len_q == '0 || ptr_q < len_q), "drain past line")

endmodule
